// ===== rtl/zoned_pd_steering_with_wheel_targets_core_assert.svh =====
// Assertion macros used by the steering core controller.
`ifndef ZONED_PD_STEERING_WITH_WHEEL_TARGETS_CORE_ASSERT_SVH
`define ZONED_PD_STEERING_WITH_WHEEL_TARGETS_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zpd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ZPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zpd assertion failed");

`endif

// ===== rtl/zpd_pkg.sv =====
// Types and constants of the zoned PD steering core.
package zpd_pkg;

    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int ERR_W    = 10;
    localparam int DELTA_W  = 11;
    localparam int MAG_W    = 9;
    localparam int GAIN_W   = 4;
    localparam int P_W      = 15;
    localparam int D_W      = 16;
    localparam int SUM_W    = 16;
    localparam int PROD_W   = 24;
    localparam int FULL_W   = 25;
    localparam int STEER_W  = 23;
    localparam int WHEEL_W  = 13;
    localparam int SPEED_W  = 8;
    localparam int LIMIT_W  = 13;
    localparam int BOOST_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_P_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_INITIAL   = 3'd4;

    // Register reset values
    localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = 8'd96;
    localparam logic [SPEED_W-1:0] RING_SPEED_RST   = 8'd40;
    localparam logic [LIMIT_W-1:0] P_LIMIT_RST      = 13'd0;
    localparam logic [BOOST_W-1:0] BOOST_RST        = 8'd0;
    localparam logic [GAIN_W-1:0]  KD_INITIAL_RST   = 4'd0;

    // Track status codes
    localparam logic [STATUS_W-1:0] ST_CROSS    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CIRCLE_R = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CIRCLE_L = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NEAR     = 3'd4;

    // Zone bounds on the error
    localparam logic signed [ERR_W-1:0] E_NEG_30 = -10'sd30;
    localparam logic signed [ERR_W-1:0] E_NEG_18 = -10'sd18;
    localparam logic signed [ERR_W-1:0] E_NEG_13 = -10'sd13;
    localparam logic signed [ERR_W-1:0] E_POS_13 = 10'sd13;
    localparam logic signed [ERR_W-1:0] E_POS_18 = 10'sd18;
    localparam logic signed [ERR_W-1:0] E_POS_30 = 10'sd30;

    // Gains in tenths
    localparam logic [GAIN_W-1:0] KP_LARGE  = 4'd10;
    localparam logic [GAIN_W-1:0] KP_BIG    = 4'd8;
    localparam logic [GAIN_W-1:0] KP_MID    = 4'd6;
    localparam logic [GAIN_W-1:0] KP_SMALL  = 4'd5;
    localparam logic [GAIN_W-1:0] KD_LARGE  = 4'd10;
    localparam logic [GAIN_W-1:0] KD_BIG    = 4'd7;

    // Wheel differential per unit of error, tenths
    localparam logic [GAIN_W-1:0] DIFF_BIG_NORMAL = 4'd5;
    localparam logic [GAIN_W-1:0] DIFF_BIG_CIRCLE = 4'd10;
    localparam logic [GAIN_W-1:0] DIFF_MID_NORMAL = 4'd1;
    localparam logic [GAIN_W-1:0] DIFF_MID_CIRCLE = 4'd2;
    localparam logic [GAIN_W-1:0] DIFF_NONE       = 4'd0;
    localparam logic [WHEEL_W-1:0] SPEED_SCALE    = 13'd10;

    // Servo command in 1/160 degree
    localparam logic signed [FULL_W-1:0] STEER_CENTER = 25'sd14400;
    localparam logic signed [FULL_W-1:0] STEER_MAX    = 25'sd4194303;
    localparam logic signed [FULL_W-1:0] STEER_MIN    = -25'sd4194304;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZONE,
        S_PD,
        S_SUM,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic zone;
        logic pd;
        logic sum;
        logic mul;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/zpd_in_if.sv =====
// Input item channel: line position, target position and track status.
interface zpd_in_if import zpd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    line_pos;
    logic [POS_W-1:0]    target_pos;
    logic [STATUS_W-1:0] track_status;

    modport source (output valid, output line_pos, output target_pos,
                    output track_status, input ready);
    modport sink   (input valid, input line_pos, input target_pos,
                    input track_status, output ready);
endinterface

// ===== rtl/zpd_out_if.sv =====
// Result item channel: servo angle and wheel targets.
interface zpd_out_if import zpd_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [STEER_W-1:0]  steer_angle;
    logic [WHEEL_W-1:0]         left_target;
    logic [WHEEL_W-1:0]         right_target;

    modport source (output valid, output steer_angle, output left_target,
                    output right_target, input ready);
    modport sink   (input valid, input steer_angle, input left_target,
                    input right_target, output ready);
endinterface

// ===== rtl/zpd_datapath.sv =====
// Datapath: config registers, zone decode, PD terms, gain multiply, output register.
module zpd_datapath import zpd_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  logic [POS_W-1:0]           i_line_pos,
    input  logic [POS_W-1:0]           i_target_pos,
    input  logic [STATUS_W-1:0]        i_track_status,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [STEER_W-1:0]  o_steer_angle,
    output logic [WHEEL_W-1:0]         o_left_target,
    output logic [WHEEL_W-1:0]         o_right_target
);

    logic [SPEED_W-1:0]        r_cruise_speed;
    logic [SPEED_W-1:0]        r_ring_speed;
    logic [LIMIT_W-1:0]        r_p_limit;
    logic [BOOST_W-1:0]        r_boost;
    logic [GAIN_W-1:0]         r_kd_gain;
    logic signed [ERR_W-1:0]   r_last_error;
    logic                      r_circle_mode;

    logic [POS_W-1:0]          r_lp;
    logic [POS_W-1:0]          r_tp;
    logic [STATUS_W-1:0]       r_status;

    logic signed [ERR_W-1:0]   r_err;
    logic signed [DELTA_W-1:0] r_delta;
    logic [GAIN_W-1:0]         r_kp;
    logic                      r_big;
    logic                      r_mid;

    logic signed [P_W-1:0]     r_p;
    logic signed [D_W-1:0]     r_d;
    logic [WHEEL_W-1:0]        r_left;
    logic [WHEEL_W-1:0]        r_right;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [PROD_W-1:0]  r_prod;

    logic                      r_out_valid;
    logic signed [STEER_W-1:0] r_steer_o;
    logic [WHEEL_W-1:0]        r_left_o;
    logic [WHEEL_W-1:0]        r_right_o;

    // zone stage
    logic signed [POS_W:0]     dpos;
    logic signed [ERR_W-1:0]   err_c;
    logic [GAIN_W-1:0]         kp_c;
    logic [GAIN_W-1:0]         kd_c;
    logic                      big_c;
    logic                      mid_c;
    logic                      mode_c;

    // PD stage
    logic signed [P_W-1:0]     p_raw;
    logic signed [P_W-1:0]     lim_pos;
    logic signed [P_W-1:0]     lim_neg;
    logic signed [P_W-1:0]     p_clamp;
    logic signed [D_W-1:0]     d_raw;
    logic [MAG_W-1:0]          mag;
    logic [GAIN_W-1:0]         coef;
    logic [WHEEL_W-1:0]        diff;
    logic [WHEEL_W-1:0]        base10;

    // output stage
    logic signed [FULL_W-1:0]  steer_full;
    logic signed [FULL_W-1:0]  steer_sat;

    always_comb begin
        dpos  = $signed({1'b0, r_lp}) - $signed({1'b0, r_tp});
        err_c = $signed({dpos, 1'b0});
        big_c = 1'b0;
        mid_c = 1'b0;
        kd_c  = r_kd_gain;
        if (err_c < E_NEG_30) begin
            kp_c = KP_LARGE;
            kd_c = KD_LARGE;
            big_c = 1'b1;
        end else if (err_c <= E_NEG_18) begin
            kp_c = KP_BIG;
            kd_c = KD_BIG;
            big_c = 1'b1;
        end else if (err_c < E_NEG_13) begin
            kp_c = KP_MID;
            mid_c = 1'b1;
        end else if (err_c <= E_POS_13) begin
            kp_c = KP_SMALL;
        end else if (err_c < E_POS_18) begin
            kp_c = KP_MID;
            mid_c = 1'b1;
        end else if (err_c < E_POS_30) begin
            kp_c = KP_BIG;
            kd_c = KD_BIG;
            big_c = 1'b1;
        end else begin
            kp_c = KP_LARGE;
            kd_c = KD_LARGE;
            big_c = 1'b1;
        end

        // circle entry is sticky; centerline near then follows the zone
        mode_c = r_circle_mode;
        if (r_status == ST_CROSS || r_status == ST_CIRCLE_R || r_status == ST_CIRCLE_L) begin
            mode_c = 1'b1;
        end
        if (r_status == ST_NEAR) begin
            mode_c = big_c;
        end
    end

    always_comb begin
        p_raw   = $signed({1'b0, r_kp}) * r_err;
        lim_pos = $signed({2'b00, r_p_limit});
        lim_neg = -lim_pos;
        p_clamp = p_raw;
        if (p_raw < lim_neg) begin
            p_clamp = lim_neg;
        end
        if (p_raw > lim_pos) begin
            p_clamp = lim_pos;
        end
        d_raw = $signed({1'b0, r_kd_gain}) * r_delta;

        mag = r_err[ERR_W-1] ? MAG_W'(-r_err) : MAG_W'(r_err);
        if (r_big) begin
            coef = r_circle_mode ? DIFF_BIG_CIRCLE : DIFF_BIG_NORMAL;
        end else if (r_mid) begin
            coef = r_circle_mode ? DIFF_MID_CIRCLE : DIFF_MID_NORMAL;
        end else begin
            coef = DIFF_NONE;
        end
        diff   = WHEEL_W'(coef) * WHEEL_W'(mag);
        base10 = WHEEL_W'(r_circle_mode ? r_ring_speed : r_cruise_speed) * SPEED_SCALE;
    end

    always_comb begin
        steer_full = STEER_CENTER - FULL_W'(r_prod);
        steer_sat  = steer_full;
        if (steer_full > STEER_MAX) begin
            steer_sat = STEER_MAX;
        end
        if (steer_full < STEER_MIN) begin
            steer_sat = STEER_MIN;
        end
    end

    // config registers and carried state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise_speed <= CRUISE_SPEED_RST;
            r_ring_speed   <= RING_SPEED_RST;
            r_p_limit      <= P_LIMIT_RST;
            r_boost        <= BOOST_RST;
            r_kd_gain      <= KD_INITIAL_RST;
            r_last_error   <= '0;
            r_circle_mode  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRUISE_SPEED: r_cruise_speed <= i_cfg_data[SPEED_W-1:0];
                    CFG_RING_SPEED:   r_ring_speed   <= i_cfg_data[SPEED_W-1:0];
                    CFG_P_LIMIT:      r_p_limit      <= i_cfg_data[LIMIT_W-1:0];
                    CFG_BOOST:        r_boost        <= i_cfg_data[BOOST_W-1:0];
                    CFG_KD_INITIAL:   r_kd_gain      <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end else if (i_cmd.zone) begin
                r_kd_gain <= kd_c;
            end
            if (i_cmd.zone) begin
                r_last_error  <= err_c;
                r_circle_mode <= mode_c;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lp     <= i_line_pos;
            r_tp     <= i_target_pos;
            r_status <= i_track_status;
        end
        if (i_cmd.zone) begin
            r_err   <= err_c;
            r_delta <= DELTA_W'(err_c) - DELTA_W'(r_last_error);
            r_kp    <= kp_c;
            r_big   <= big_c;
            r_mid   <= mid_c;
        end
        if (i_cmd.pd) begin
            r_p     <= p_clamp;
            r_d     <= d_raw;
            if (r_err[ERR_W-1]) begin
                r_left  <= base10;
                r_right <= base10 + diff;
            end else begin
                r_left  <= base10 + diff;
                r_right <= base10;
            end
        end
        if (i_cmd.sum) begin
            r_sum <= SUM_W'(r_p) + r_d;
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_boost}) * r_sum;
        end
        if (i_cmd.out_load) begin
            r_steer_o <= steer_sat[STEER_W-1:0];
            r_left_o  <= r_left;
            r_right_o <= r_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_steer_angle  = r_steer_o;
    assign o_left_target  = r_left_o;
    assign o_right_target = r_right_o;

endmodule

// ===== rtl/zpd_ctrl.sv =====
// Controller: sequences one item through the datapath stages.
`include "zoned_pd_steering_with_wheel_targets_core_assert.svh"

module zpd_ctrl import zpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ZONE;
                end
            end
            S_ZONE: n_state = S_PD;
            S_PD:   n_state = S_SUM;
            S_SUM:  n_state = S_MUL;
            S_MUL:  n_state = S_OUT;
            S_OUT: begin
                // hold until the output register can take the result
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_ZONE: o_cmd.zone = 1'b1;
            S_PD:   o_cmd.pd   = 1'b1;
            S_SUM:  o_cmd.sum  = 1'b1;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_OUT:  o_cmd.out_load = !i_sts.out_busy;
            default: ;
        endcase
    end

    `ZPD_ASSERT_NEXT(a_accept_to_zone, i_clk, i_rst_n, i_in_valid && o_in_ready, o_cmd.zone)
    `ZPD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !i_sts.out_busy)
    `ZPD_ASSERT_NOW(a_one_command, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd))
    `ZPD_ASSERT_NEXT(a_mul_then_out, i_clk, i_rst_n, o_cmd.mul, o_cmd.out_load || i_sts.out_busy)

endmodule

// ===== rtl/zoned_pd_steering_with_wheel_targets_core.sv =====
// Top level of the zoned PD steering core with wheel speed targets.
//
// Input channel i_in carries line_pos, target_pos and track_status; output
// channel o_out carries steer_angle, left_target and right_target. Both move
// one item per edge at which valid and ready are high.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 cruise_speed, 1 ring_speed, 2 p_limit, 3 boost, 4 kd_initial, which
// also loads the derivative gain). Write only while no item is in flight.
// An item walks through zone decode, PD terms, sum, boost multiply and output
// load one step at a time under the controller, so no new item is taken until
// the last one has passed its output load; i_in.ready is high only in the idle
// state.
// The output register holds the result while o_out.ready is low; the next
// item may be accepted meanwhile and waits in its last step until the
// register frees up.
// Reset (i_rst_n low at an edge) restores register defaults, clears the
// previous error, the derivative gain and circle mode, and drops any
// pending result.
module zoned_pd_steering_with_wheel_targets_core import zpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    zpd_in_if.sink                i_in,
    zpd_out_if.source             o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    zpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    zpd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_line_pos     (i_in.line_pos),
        .i_target_pos   (i_in.target_pos),
        .i_track_status (i_in.track_status),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_steer_angle  (o_out.steer_angle),
        .o_left_target  (o_out.left_target),
        .o_right_target (o_out.right_target)
    );

    assign i_in.ready = in_ready;

endmodule

// ===== dv/zpd_steer_checker.sv =====
// Checker for the steering core: mirrors registers and state, predicts and compares results.
`timescale 1ns / 1ps

module zpd_steer_checker import zpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    zpd_in_if                     i_in,
    zpd_out_if                    i_res,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    typedef struct packed {
        logic signed [STEER_W-1:0] steer;
        logic [WHEEL_W-1:0]        left;
        logic [WHEEL_W-1:0]        right;
    } t_steer_cmd;

    logic [SPEED_W-1:0]      cruise_speed_q;
    logic [SPEED_W-1:0]      ring_speed_q;
    logic [LIMIT_W-1:0]      p_limit_q;
    logic [BOOST_W-1:0]      boost_q;
    logic [GAIN_W-1:0]       kd_gain_q;
    logic signed [ERR_W-1:0] prev_err_q;
    logic                    circle_q;

    t_steer_cmd pending_cmds[$];
    int         fail_cnt = 0;
    int         checked_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;

    // Compute the servo and wheel command for one item and advance the state.
    function automatic t_steer_cmd next_steer_cmd(input logic [POS_W-1:0] lp,
                                                  input logic [POS_W-1:0] tp,
                                                  input logic [STATUS_W-1:0] st);
        int         err;
        int         kp;
        int         mag;
        int         coef;
        int         base10;
        int         lft;
        int         rgt;
        int         p;
        int         d;
        int         lim;
        logic       big;
        longint     steer;
        t_steer_cmd c;

        err = 2 * (int'(lp) - int'(tp));
        big = 1'b0;
        if (st == ST_CROSS || st == ST_CIRCLE_R || st == ST_CIRCLE_L)
            circle_q = 1'b1;

        if (err < int'(E_NEG_30)) begin
            kp = int'(KP_LARGE); kd_gain_q = KD_LARGE; big = 1'b1;
        end else if (err <= int'(E_NEG_18)) begin
            kp = int'(KP_BIG); kd_gain_q = KD_BIG; big = 1'b1;
        end else if (err < int'(E_NEG_13)) begin
            kp = int'(KP_MID);
        end else if (err <= int'(E_POS_13)) begin
            kp = int'(KP_SMALL);
        end else if (err < int'(E_POS_18)) begin
            kp = int'(KP_MID);
        end else if (err < int'(E_POS_30)) begin
            kp = int'(KP_BIG); kd_gain_q = KD_BIG; big = 1'b1;
        end else begin
            kp = int'(KP_LARGE); kd_gain_q = KD_LARGE; big = 1'b1;
        end

        // Centerline near: mode follows the zone size
        if (st == ST_NEAR)
            circle_q = big;

        mag = (err < 0) ? -err : err;
        if (big)
            coef = circle_q ? int'(DIFF_BIG_CIRCLE) : int'(DIFF_BIG_NORMAL);
        else if (kp == int'(KP_MID))
            coef = circle_q ? int'(DIFF_MID_CIRCLE) : int'(DIFF_MID_NORMAL);
        else
            coef = int'(DIFF_NONE);
        base10 = int'(circle_q ? ring_speed_q : cruise_speed_q) * int'(SPEED_SCALE);
        if (err < 0) begin
            lft = base10;
            rgt = base10 + coef * mag;
        end else begin
            lft = base10 + coef * mag;
            rgt = base10;
        end

        lim = int'(p_limit_q);
        p = kp * err;
        if (p < -lim) p = -lim;
        if (p > lim) p = lim;
        d = int'(kd_gain_q) * (err - int'(prev_err_q));

        steer = longint'(STEER_CENTER) - longint'(boost_q) * longint'(p + d);
        if (steer > longint'(STEER_MAX)) steer = longint'(STEER_MAX);
        if (steer < longint'(STEER_MIN)) steer = longint'(STEER_MIN);

        prev_err_q = err[ERR_W-1:0];
        c.steer = steer[STEER_W-1:0];
        c.left  = lft[WHEEL_W-1:0];
        c.right = rgt[WHEEL_W-1:0];
        return c;
    endfunction

    task automatic flag_field(input string fld, input longint want, input longint got);
        if (want != got) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("[%0t] %s wrong: expected %0d, got %0d", $time, fld, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_steer_cmd want;
        if (!i_rst_n) begin
            cruise_speed_q = CRUISE_SPEED_RST;
            ring_speed_q   = RING_SPEED_RST;
            p_limit_q      = P_LIMIT_RST;
            boost_q        = BOOST_RST;
            kd_gain_q      = KD_INITIAL_RST;
            prev_err_q     = '0;
            circle_q       = 1'b0;
            pending_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRUISE_SPEED: cruise_speed_q = i_cfg_data[SPEED_W-1:0];
                    CFG_RING_SPEED:   ring_speed_q   = i_cfg_data[SPEED_W-1:0];
                    CFG_P_LIMIT:      p_limit_q      = i_cfg_data[LIMIT_W-1:0];
                    CFG_BOOST:        boost_q        = i_cfg_data[BOOST_W-1:0];
                    CFG_KD_INITIAL:   kd_gain_q      = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            // Retire before predicting so a same-edge item never meets its own entry
            if (i_res.valid && i_res.ready) begin
                if (pending_cmds.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("[%0t] result item arrived with nothing pending: steer %0d",
                                 $time, i_res.steer_angle);
                end else begin
                    want = pending_cmds.pop_front();
                    flag_field("steer_angle", longint'(want.steer),
                               longint'(i_res.steer_angle));
                    flag_field("left_target", longint'(want.left),
                               longint'(i_res.left_target));
                    flag_field("right_target", longint'(want.right),
                               longint'(i_res.right_target));
                    checked_cnt++;
                end
            end
            if (i_in.valid && i_in.ready)
                pending_cmds.push_back(next_steer_cmd(i_in.line_pos, i_in.target_pos,
                                                      i_in.track_status));
        end
        o_pending <= pending_cmds.size();
    end

endmodule

// ===== dv/tb_zoned_pd_steering_with_wheel_targets_core.sv =====
// Testbench top for the steering core: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_zoned_pd_steering_with_wheel_targets_core;
    import zpd_pkg::*;

    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 88;
    localparam int NUM_PHASES   = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    zpd_in_if  in_ch();
    zpd_out_if out_ch();

    int fail_count;
    int pending;
    int checked;
    int items_sent = 0;
    int settings_done = 0;
    int hold_req = 0;
    int hold_done = 0;
    logic calm = 1'b0;

    zoned_pd_steering_with_wheel_targets_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    zpd_steer_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .i_res       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int gap;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done++;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                gap = pick_gap();
                out_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [POS_W-1:0] lp, input logic [POS_W-1:0] tp,
                             input logic [STATUS_W-1:0] st);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid        <= 1'b0;
            in_ch.line_pos     <= POS_W'($urandom);
            in_ch.target_pos   <= POS_W'($urandom);
            in_ch.track_status <= STATUS_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.line_pos     <= lp;
        in_ch.target_pos   <= tp;
        in_ch.track_status <= st;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every pending result is back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] ns, input logic [CFG_DATA_W-1:0] cs,
                             input logic [CFG_DATA_W-1:0] pl, input logic [CFG_DATA_W-1:0] bo,
                             input logic [CFG_DATA_W-1:0] kd);
        write_reg(CFG_CRUISE_SPEED, ns);
        write_reg(CFG_RING_SPEED, cs);
        write_reg(CFG_P_LIMIT, pl);
        write_reg(CFG_BOOST, bo);
        write_reg(CFG_KD_INITIAL, kd);
        settings_done++;
    endtask

    initial begin : stimulus
        int                  r;
        int                  lp_i;
        int                  tp_i;
        logic [STATUS_W-1:0] st;

        in_ch.valid        = 1'b0;
        in_ch.line_pos     = '0;
        in_ch.target_pos   = '0;
        in_ch.track_status = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: wheel outputs, mode entry and exit
        send_item(8'd0, 8'd255, 3'd0);
        send_item(8'd255, 8'd0, 3'd0);
        send_item(8'd128, 8'd128, ST_CROSS);
        send_item(8'd143, 8'd128, ST_NEAR);
        send_item(8'd121, 8'd128, ST_NEAR);
        send_item(8'd140, 8'd100, 3'd7);
        drain();

        // Full swing and every zone bound at high gain
        write_all(13'd200, 13'd30, 13'd8191, 13'd255, 13'd10);
        send_item(8'd255, 8'd0, 3'd0);
        send_item(8'd0, 8'd255, 3'd0);
        send_item(8'd113, 8'd128, 3'd0);
        send_item(8'd114, 8'd128, ST_CIRCLE_R);
        send_item(8'd119, 8'd128, 3'd0);
        send_item(8'd120, 8'd128, ST_CIRCLE_L);
        send_item(8'd121, 8'd128, ST_NEAR);
        send_item(8'd122, 8'd128, 3'd0);
        send_item(8'd128, 8'd128, 3'd5);
        send_item(8'd134, 8'd128, 3'd6);
        send_item(8'd135, 8'd128, ST_NEAR);
        send_item(8'd137, 8'd128, 3'd0);
        send_item(8'd142, 8'd128, ST_CROSS);
        send_item(8'd143, 8'd128, ST_NEAR);
        send_item(8'd128, 8'd128, ST_NEAR);
        send_item(8'd255, 8'd255, 3'd7);
        send_item(8'd0, 8'd0, 3'd0);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: write_all(13'd255, 13'd255, 13'd8191, 13'd255, 13'd15);
                1: write_all(13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
                // upper bits of the data word are dropped by the register
                3: write_all(13'h1E60, 13'd40, 13'd5100, 13'd16, 13'd10);
                5: write_all(13'd255, 13'd0, 13'($urandom_range(0, 8191)), 13'd255,
                             13'($urandom_range(0, 10)));
                default: write_all(13'($urandom_range(0, 255)), 13'($urandom_range(0, 255)),
                                   13'($urandom_range(0, 5100)), 13'($urandom_range(0, 255)),
                                   13'($urandom_range(0, 10)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 15) calm = 1'b1;
                if (i == 30) calm = 1'b0;
                if ((ph == 1 || ph == 4) && i == 45) begin
                    calm = 1'b1;
                    hold_req++;
                end
                if (i == 70) begin
                    calm = 1'b0;
                    drain();
                end
                tp_i = $urandom_range(0, 255);
                if ($urandom_range(0, 9) < 7) begin
                    lp_i = tp_i + int'($urandom_range(0, 44)) - 22;
                    if (lp_i < 0) lp_i = 0;
                    if (lp_i > 255) lp_i = 255;
                end else begin
                    lp_i = $urandom_range(0, 255);
                end
                r = $urandom_range(0, 19);
                st = (r < 17) ? STATUS_W'(r % 5) : STATUS_W'($urandom_range(5, 7));
                send_item(lp_i[POS_W-1:0], tp_i[POS_W-1:0], st);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d items under %0d register settings; %0d results compared.",
                 items_sent, settings_done, checked);
        $display("Included zone bounds, all status codes, %0d long output hold-offs and drains.",
                 hold_done);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
